// File: design/xs256_pkg.sv
// Package with the beat types, the splitmix64 constants and the multiplier control struct.
`timescale 1ns / 1ps
`default_nettype none
package xs256_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned UNIF_W = 54;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] seed;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic [UNIF_W-1:0] uniform_open;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic sel_b;
  } mul_ctl_t;

endpackage
`default_nettype wire

// File: design/xs256_mul.sv
// Shared 32x32 multiplier that forms the low 64 bits of an operand times a mixing constant.
`timescale 1ns / 1ps
`default_nettype none
module xs256_mul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire xs256_pkg::mul_ctl_t       ctl,
  input  wire logic [xs256_pkg::WORD_W-1:0] operand,
  output logic                           done,
  output logic [xs256_pkg::WORD_W-1:0]   product
);
  import xs256_pkg::*;

  localparam int unsigned HALF_W = WORD_W / 2;

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;
  localparam logic [1:0] PH_FIN = 2'd3;

  logic [WORD_W-1:0] a_r, c_r, acc_r, pp_r;
  logic [1:0]        phase_r;
  logic              busy_r, done_r;
  logic [HALF_W-1:0] mx_a, mx_c;
  logic [WORD_W-1:0] mx_p;

  assign mx_a = (phase_r == PH_HL) ? a_r[WORD_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign mx_c = (phase_r == PH_LH) ? c_r[WORD_W-1:HALF_W] : c_r[HALF_W-1:0];
  assign mx_p = WORD_W'(mx_a) * WORD_W'(mx_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_LL;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r  <= 1'b1;
        phase_r <= PH_LL;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == PH_FIN) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= operand;
      c_r <= ctl.sel_b ? MIX_MUL_B : MIX_MUL_A;
    end else if (busy_r) begin
      pp_r <= mx_p;
      case (phase_r)
        PH_LL: acc_r <= acc_r;
        PH_LH: acc_r <= pp_r;
        PH_HL: acc_r <= acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};
        PH_FIN: acc_r <= acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
`default_nettype wire

// File: design/xoshiro256ss_generator_top.sv
// Top level of the xoshiro256** generator with splitmix64 seeding.
// The input channel takes one beat per item: operation selects a draw or a
// reseed, and seed is used only by a reseed.
// A draw returns one output beat with the xoshiro256** word and the open
// interval numerator (word >> 11) + 1, which stands for a value in (0,1].
// A reseed returns no beat and fills the four state words from the seed.
// The output beat of a draw is registered after the states S_DRAW1 and
// S_DRAW2, and the next item is taken once the block is back in idle, so a
// new draw cannot start before the last one has finished; the state update
// and the two shift-add multiplies are done in those two states.
// A reseed runs four splitmix64 steps through one shared 32x32 multiplier,
// three partial products per 64-bit multiply.
// The block is not ready while an item is in work.
// After reset the block runs the same expansion with seed zero and holds
// in_ready low until that expansion is done.
// The output beat is registered; while the receiver stalls it holds, and
// the next item is still accepted, though a draw cannot finish until the
// waiting beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module xoshiro256ss_generator_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire xs256_pkg::in_beat_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output xs256_pkg::out_beat_t      out_data
);
  import xs256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_MULA  = 3'd2;
  localparam logic [2:0] S_MULB  = 3'd3;
  localparam logic [2:0] S_DRAW1 = 3'd4;
  localparam logic [2:0] S_DRAW2 = 3'd5;

  logic [2:0]        st_r;
  logic [1:0]        idx_r;
  logic [WORD_W-1:0] sm_acc_r;
  logic [WORD_W-1:0] words_r [4];
  logic [WORD_W-1:0] t_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  mul_ctl_t          mctl;
  logic [WORD_W-1:0] m_opnd, m_prod, sm_sum, times5, draw_word;
  logic              m_done, in_fire, out_free;

  assign in_ready = (st_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign sm_sum   = sm_acc_r + GOLDEN_GAMMA;
  assign times5   = words_r[1] + {words_r[1][WORD_W-3:0], 2'b00};
  assign draw_word = t_r + {t_r[WORD_W-4:0], 3'b000};

  always_comb begin
    mctl.start = 1'b0;
    mctl.sel_b = 1'b0;
    m_opnd     = sm_sum ^ (sm_sum >> 30);
    if (st_r == S_ADD) begin
      mctl.start = 1'b1;
    end else if (st_r == S_MULA && m_done) begin
      mctl.start = 1'b1;
      mctl.sel_b = 1'b1;
      m_opnd     = m_prod ^ (m_prod >> 27);
    end
  end

  xs256_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .operand (m_opnd),
    .done    (m_done),
    .product (m_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_ADD;
      idx_r       <= 2'd0;
      sm_acc_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_DRAW2 && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.operation == OP_RESEED) begin
              sm_acc_r <= in_data.seed;
              idx_r    <= 2'd0;
              st_r     <= S_ADD;
            end else begin
              st_r <= S_DRAW1;
            end
          end
        end
        S_ADD: begin
          sm_acc_r <= sm_sum;
          st_r     <= S_MULA;
        end
        S_MULA: begin
          if (m_done) begin
            st_r <= S_MULB;
          end
        end
        S_MULB: begin
          if (m_done) begin
            idx_r <= idx_r + 2'd1;
            st_r  <= (idx_r == 2'd3) ? S_IDLE : S_ADD;
          end
        end
        S_DRAW1: begin
          st_r <= S_DRAW2;
        end
        S_DRAW2: begin
          if (out_free) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_MULB && m_done) begin
      words_r[idx_r] <= m_prod ^ (m_prod >> 31);
    end
    if (st_r == S_DRAW1) begin
      t_r        <= {times5[WORD_W-8:0], times5[WORD_W-1:WORD_W-7]};
      words_r[0] <= words_r[0] ^ words_r[1] ^ words_r[3];
      words_r[1] <= words_r[1] ^ words_r[2] ^ words_r[0];
      words_r[2] <= words_r[2] ^ words_r[0] ^ {words_r[1][WORD_W-18:0], 17'd0};
      words_r[3] <= {(words_r[3][WORD_W-46:0] ^ words_r[1][WORD_W-46:0]),
                     (words_r[3][WORD_W-1:WORD_W-45] ^ words_r[1][WORD_W-1:WORD_W-45])};
    end
    if (st_r == S_DRAW2 && out_free) begin
      out_data_r.random_word  <= draw_word;
      out_data_r.uniform_open <= {1'b0, draw_word[WORD_W-1:11]} + UNIF_W'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the xoshiro256** generator with splitmix64 seeding.
`timescale 1ns / 1ps
module testbench;
  import xs256_pkg::*;

  localparam int RANDOM_ITEMS  = 730;
  localparam int CALM_FROM     = 640;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int REPORT_LIMIT  = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_beat_t out_data;

  logic [WORD_W-1:0] gen_words [4];
  out_beat_t         expected_draws [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                stall_left = 0;
  bit                quiet_tail = 1'b0;

  in_beat_t stim_table [0:21] = '{
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'hffff_ffff_ffff_ffff},
    {OP_DRAW,   64'h5555_5555_5555_5555},
    {OP_RESEED, 64'h0000_0000_0000_0000},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_RESEED, 64'hffff_ffff_ffff_ffff},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'hffff_ffff_ffff_ffff},
    {OP_RESEED, 64'h8000_0000_0000_0000},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_RESEED, 64'h0000_0000_0000_0001},
    {OP_RESEED, 64'haaaa_aaaa_aaaa_aaaa},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_RESEED, 64'h5555_5555_5555_5555},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'haaaa_aaaa_aaaa_aaaa},
    // This seed wraps the first splitmix64 sum to zero, so state word zero is zero.
    {OP_RESEED, 64'h61c8_8646_80b5_83eb},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'h0000_0000_0000_0000},
    {OP_DRAW,   64'h0000_0000_0000_0000}
  };

  xoshiro256ss_generator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void splitmix_fill(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] m;
    acc = seed;
    for (int i = 0; i < 4; i++) begin
      acc = acc + GOLDEN_GAMMA;
      m = (acc ^ (acc >> 30)) * MIX_MUL_A;
      m = (m ^ (m >> 27)) * MIX_MUL_B;
      gen_words[i] = m ^ (m >> 31);
    end
  endfunction

  function automatic out_beat_t xoshiro_draw();
    logic [WORD_W-1:0] times5;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] w3;
    out_beat_t r;
    times5 = gen_words[1] * 64'd5;
    r.random_word = {times5[56:0], times5[63:57]} * 64'd9;
    r.uniform_open = {1'b0, r.random_word[63:11]} + 54'd1;
    shifted = gen_words[1] << 17;
    gen_words[2] = gen_words[2] ^ gen_words[0];
    gen_words[3] = gen_words[3] ^ gen_words[1];
    gen_words[1] = gen_words[1] ^ gen_words[2];
    gen_words[0] = gen_words[0] ^ gen_words[3];
    gen_words[2] = gen_words[2] ^ shifted;
    w3 = gen_words[3];
    gen_words[3] = {w3[18:0], w3[63:19]};
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    if (rst_n && in_valid && in_ready) begin
      if (in_data.operation == OP_RESEED) begin
        splitmix_fill(in_data.seed);
      end else begin
        expected_draws.insert(expected_draws.size(), xoshiro_draw());
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_draws.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("%0t: unexpected output beat %h", $realtime, out_data);
        end
        mismatches++;
      end else begin
        want = expected_draws.pop_front();
        if (out_data.random_word !== want.random_word) begin
          note_mismatch("random_word", want.random_word, out_data.random_word);
        end
        if (out_data.uniform_open !== want.uniform_open) begin
          note_mismatch("uniform_open", 64'(want.uniform_open), 64'(out_data.uniform_open));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (quiet_tail) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input in_beat_t beat);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    in_beat_t beat;
    splitmix_fill(64'd0);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      send_beat(stim_table[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_tail = (i >= CALM_FROM);
      beat.operation = ($urandom_range(0, 7) == 0) ? OP_RESEED : OP_DRAW;
      beat.seed = {$urandom, $urandom};
      send_beat(beat);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
design/xs256_pkg.sv
design/xs256_mul.sv
design/xoshiro256ss_generator_top.sv
sim/testbench.sv
